// ----- src/assert_macros.svh -----
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset
`define SPR_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication under reset
`define SPR_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ----- src/spr_pkg.sv -----
// Shared types and constants for the servo position reply parser
`timescale 1ns / 1ps
package spr_pkg;

  localparam logic [7:0] CH_START  = 8'h23;
  localparam logic [7:0] CH_SEP    = 8'h50;
  localparam logic [7:0] CH_END    = 8'h21;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [3:0] FRAME_LEN = 4'd10;
  localparam logic [3:0] POS_SEP   = 4'd4;
  localparam logic [3:0] POS_END   = 4'd9;
  localparam logic [3:0] POS_SRV_LAST = 4'd3;
  localparam logic [13:0] PULSE_MAX = 14'd9999;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TIMEOUT   = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_MISMATCH  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    TK_TIMEOUT = 3'd0,
    TK_START   = 3'd1,
    TK_SEP     = 3'd2,
    TK_END     = 3'd3,
    TK_DIGIT   = 3'd4,
    TK_OTHER   = 3'd5
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [3:0]  digit;
  } token_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_stat_t;

endpackage

// ----- src/spr_front.sv -----
// Front end: accept requests and classify each byte into a token
`timescale 1ns / 1ps
module spr_front
  import spr_pkg::*;
(
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  queue_stat_t q_stat,
  output logic        push,
  output token_t      push_tok
);

  logic is_digit;
  logic [7:0] digit_off;

  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && !q_stat.full;
  assign is_digit  = (in_tdata >= CH_ZERO) && (in_tdata <= CH_NINE);
  assign digit_off = in_tdata - CH_ZERO;

  always_comb begin
    push_tok.digit = 4'd0;
    priority if (in_tuser) begin
      push_tok.kind = TK_TIMEOUT;
    end else if (in_tdata == CH_START) begin
      push_tok.kind = TK_START;
    end else if (in_tdata == CH_SEP) begin
      push_tok.kind = TK_SEP;
    end else if (in_tdata == CH_END) begin
      push_tok.kind = TK_END;
    end else if (is_digit) begin
      push_tok.kind  = TK_DIGIT;
      push_tok.digit = digit_off[3:0];
    end else begin
      push_tok.kind = TK_OTHER;
    end
  end

endmodule

// ----- src/spr_queue.sv -----
// Short token queue between front end and frame decoder
`timescale 1ns / 1ps
module spr_queue
  import spr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  token_t      push_tok,
  input  logic        pop,
  output token_t      pop_tok,
  output queue_stat_t q_stat
);

  token_t              mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]   count_r;

  assign q_stat.valid = (count_r != '0);
  assign q_stat.full  = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_tok      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- src/spr_back.sv -----
// Back end: frame decoder, servo check and result register
`timescale 1ns / 1ps
module spr_back
  import spr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_wdata,
  input  queue_stat_t q_stat,
  input  token_t      tok,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic [1:0]  out_tuser
);

  logic [9:0]  expected_r;
  logic [3:0]  idx_r, idx_nxt;
  logic [9:0]  servo_r, servo_nxt;
  logic [13:0] pulse_r, pulse_nxt;
  logic        bad_r, bad_nxt;
  logic        out_valid_r;
  status_t     status_r, status_nxt;
  logic [13:0] opulse_r, opulse_nxt;
  logic        has_res;

  logic [13:0] servo_ext, servo_acc, pulse_acc;
  logic [3:0]  idx_inc;
  logic        is_dig, bad_now;

  assign pop       = q_stat.valid && (!out_valid_r || out_tready);
  assign servo_ext = {4'd0, servo_r};
  assign servo_acc = (servo_ext << 3) + (servo_ext << 1) + {10'd0, tok.digit};
  assign pulse_acc = (pulse_r << 3) + (pulse_r << 1) + {10'd0, tok.digit};
  assign idx_inc   = idx_r + 4'd1;
  assign is_dig    = (tok.kind == TK_DIGIT);

  always_comb begin
    idx_nxt    = idx_r;
    servo_nxt  = servo_r;
    pulse_nxt  = pulse_r;
    bad_nxt    = bad_r;
    status_nxt = ST_OK;
    opulse_nxt = 14'd0;
    has_res    = 1'b0;
    bad_now    = bad_r;
    priority if (tok.kind == TK_TIMEOUT) begin
      has_res    = 1'b1;
      status_nxt = ST_TIMEOUT;
      idx_nxt    = 4'd0;
      servo_nxt  = 10'd0;
      pulse_nxt  = 14'd0;
      bad_nxt    = 1'b0;
    end else if (idx_r == 4'd0 && tok.kind != TK_START) begin
      // drop while hunting
    end else begin
      priority if (idx_r == 4'd0) begin
      end else if (idx_r == POS_SEP) begin
        bad_now = bad_r || (tok.kind != TK_SEP);
      end else if (idx_r == POS_END) begin
        bad_now = bad_r || (tok.kind != TK_END);
      end else if (idx_r <= POS_SRV_LAST) begin
        if (is_dig) begin
          servo_nxt = servo_acc[9:0];
        end else begin
          bad_now = 1'b1;
        end
      end else begin
        if (is_dig) begin
          pulse_nxt = pulse_acc;
        end else begin
          bad_now = 1'b1;
        end
      end
      bad_nxt = bad_now;
      idx_nxt = idx_inc;
      if (tok.kind == TK_END || idx_inc >= FRAME_LEN) begin
        has_res = 1'b1;
        priority if (idx_inc != FRAME_LEN || bad_now) begin
          status_nxt = ST_MALFORMED;
        end else if (servo_nxt != expected_r) begin
          status_nxt = ST_MISMATCH;
        end else begin
          status_nxt = ST_OK;
          opulse_nxt = pulse_nxt;
        end
        idx_nxt   = 4'd0;
        servo_nxt = 10'd0;
        pulse_nxt = 14'd0;
        bad_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r  <= 10'd0;
      idx_r       <= 4'd0;
      servo_r     <= 10'd0;
      pulse_r     <= 14'd0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        expected_r <= cfg_wdata;
      end
      if (pop) begin
        idx_r       <= idx_nxt;
        servo_r     <= servo_nxt;
        pulse_r     <= pulse_nxt;
        bad_r       <= bad_nxt;
        out_valid_r <= has_res;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && has_res) begin
      status_r <= status_nxt;
      opulse_r <= opulse_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, opulse_r};
  assign out_tuser  = status_r;

endmodule

// ----- src/servo_position_reply_parser_core.sv -----
// Top level of the servo position reply parser
// Parses '#', three servo digits, 'P', four pulse digits, '!' from a byte
// stream and gives one result per finished frame or timeout request. The
// block takes one request per clock while its four-entry token queue is not full;
// the queue sits between the byte classifier and the frame decoder, and a
// request that closes a frame is written into it and then decoded into the
// result register. The decoder retires one token per clock unless a result
// waits on the output.
`timescale 1ns / 1ps
module servo_position_reply_parser_core
  import spr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_wdata,   // expected_servo
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // rx_byte
  input  logic        in_tuser,    // timed_out
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // position_pulse[13:0], zero pad
  output logic [1:0]  out_tuser    // status
);

  queue_stat_t q_stat;
  logic        push, pop;
  token_t      push_tok, pop_tok;

  spr_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .push      (push),
    .push_tok  (push_tok)
  );

  spr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .pop_tok  (pop_tok),
    .q_stat   (q_stat)
  );

  spr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_stat     (q_stat),
    .tok        (pop_tok),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- src/spr_checker.sv -----
// Port-level checker for the servo position reply parser, with bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module spr_checker
  import spr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);

  `SPR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `SPR_ASSERT_NOW(a_pulse_zero, clk, rst_n, out_tvalid && out_tuser != ST_OK, out_tdata == 16'd0)
  `SPR_ASSERT_NOW(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[15:14] == 2'b00)
  `SPR_ASSERT_NOW(a_pulse_range, clk, rst_n, out_tvalid && out_tuser == ST_OK, out_tdata[13:0] <= PULSE_MAX)

endmodule

bind servo_position_reply_parser_core spr_checker u_spr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
